// File: rtl/core/video_fade_to_black_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fade-to-black unit
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef VIDEO_FADE_TO_BLACK_UNIT_MACROS_SVH
`define VIDEO_FADE_TO_BLACK_UNIT_MACROS_SVH

// same-cycle implication
`define VFTB_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("vftb check failed");

// next-cycle implication
`define VFTB_ASSERT_NXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("vftb check failed");

`endif

// File: rtl/core/vftb_pkg.sv
// ----------------------------------------------------------------------------
// vftb_pkg
// Types and constants shared by the fade-to-black unit.
// ----------------------------------------------------------------------------
package vftb_pkg;

    localparam int SAMPLE_W = 8;
    localparam int AFTER_W  = 24;
    localparam int LENGTH_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_AFTER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH = 1'b1;

    localparam logic signed [10:0] LUMA_BLACK = 11'sd16;
    localparam logic signed [10:0] CHROMA_MID = 11'sd128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic setup;
        logic step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last_step;
    } status_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
        logic                chroma;
        logic                last;
    } item_t;

endpackage

// File: rtl/core/vftb_ctrl.sv
// ----------------------------------------------------------------------------
// vftb_ctrl
// Sequencer for the gain update: setup, one divide step per cycle, commit.
// ----------------------------------------------------------------------------
module vftb_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  vftb_pkg::status_t status,
    output vftb_pkg::cmd_t   cmd,
    output logic             busy
);

    vftb_pkg::state_t state_reg;
    vftb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vftb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            vftb_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = vftb_pkg::ST_SETUP;
                end
            end
            vftb_pkg::ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = vftb_pkg::ST_DIVIDE;
            end
            vftb_pkg::ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = vftb_pkg::ST_COMMIT;
                end
            end
            vftb_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = vftb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vftb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/vftb_datapath.sv
// ----------------------------------------------------------------------------
// vftb_datapath
// Registers, frame counter, restoring gain divider and per-pixel scaling.
// ----------------------------------------------------------------------------
module vftb_datapath
#(
    parameter int GAIN_FRAC_BITS   = 16,
    parameter int FRAME_COUNT_BITS = 25
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [vftb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vftb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                pix_accept,
    input  vftb_pkg::item_t                     pix_in,
    input  vftb_pkg::cmd_t                      cmd,
    output vftb_pkg::status_t                   status,
    output vftb_pkg::item_t                     pix_out
);

    localparam int GAIN_W = GAIN_FRAC_BITS + 1;
    localparam int G3_W   = GAIN_FRAC_BITS + 2;
    localparam int CNT_W  = $clog2(GAIN_FRAC_BITS);
    localparam int MAXW   = (FRAME_COUNT_BITS > vftb_pkg::AFTER_W) ?
                            FRAME_COUNT_BITS : vftb_pkg::AFTER_W;
    localparam int SUM_W  = MAXW + 2;
    localparam int YP_W   = 9 + GAIN_W + 1;
    localparam int CP_W   = 9 + G3_W + 1;
    localparam int LW     = vftb_pkg::LENGTH_W;

    logic [FRAME_COUNT_BITS-1:0]     frame_reg;
    logic [vftb_pkg::AFTER_W-1:0]    after_reg;
    logic [LW-1:0]                   length_reg;
    logic                            fading_reg;
    logic [GAIN_W-1:0]               gain_reg;
    logic [G3_W-1:0]                 g3_reg;
    logic                            chroma_on_reg;
    logic                            zero_reg;
    logic                            zero_next;
    logic [LW-1:0]                   rem_reg;
    logic [LW-1:0]                   rem_next;
    logic [GAIN_FRAC_BITS-1:0]       quot_reg;
    logic [CNT_W-1:0]                cnt_reg;

    logic [SUM_W-1:0]                frame_ext;
    logic [SUM_W-1:0]                sum_ext;
    logic [SUM_W-1:0]                remain;
    logic                            fading_next;
    logic [LW:0]                     shifted;
    logic                            ge;
    logic [GAIN_W-1:0]               gain_new;
    logic [G3_W-1:0]                 g3_new;

    logic signed [9:0]               y_diff;
    logic signed [9:0]               cb_diff;
    logic signed [9:0]               cr_diff;
    logic signed [YP_W-1:0]          y_prod;
    logic signed [CP_W-1:0]          cb_prod;
    logic signed [CP_W-1:0]          cr_prod;
    logic signed [YP_W-1:0]          y_shr;
    logic signed [CP_W-1:0]          cb_shr;
    logic signed [CP_W-1:0]          cr_shr;
    logic signed [10:0]              y_res;
    logic signed [10:0]              cb_res;
    logic signed [10:0]              cr_res;

    function automatic logic [7:0] clamp8(input logic signed [10:0] v);
        logic [7:0] r;
        if (v < 11'sd0)
            r = 8'd0;
        else if (v > 11'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

    // gain setup and divide step
    always_comb
    begin
        frame_ext   = SUM_W'(frame_reg);
        sum_ext     = SUM_W'(after_reg) + SUM_W'(length_reg);
        remain      = sum_ext - frame_ext;
        fading_next = frame_ext > SUM_W'(after_reg);
        zero_next   = !fading_next || (length_reg == '0) || !(sum_ext > frame_ext);
        shifted     = {rem_reg, 1'b0};
        ge          = shifted >= {1'b0, length_reg};
        rem_next    = ge ? LW'(shifted - {1'b0, length_reg}) : shifted[LW-1:0];
        gain_new    = zero_reg ? '0 : GAIN_W'(quot_reg);
        g3_new      = G3_W'({gain_new, 1'b0}) + G3_W'(gain_new);
        status.last_step = cnt_reg == CNT_W'(GAIN_FRAC_BITS - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= FRAME_COUNT_BITS'(1);
            after_reg     <= '0;
            length_reg    <= '0;
            fading_reg    <= 1'b1;
            gain_reg      <= '0;
            g3_reg        <= '0;
            chroma_on_reg <= 1'b1;
            cnt_reg       <= '0;
            zero_reg      <= 1'b1;
        end
        else
        begin
            if (cfg_we && cfg_index == vftb_pkg::CFG_FADE_AFTER)
            begin
                after_reg <= cfg_data[vftb_pkg::AFTER_W-1:0];
            end
            if (cfg_we && cfg_index == vftb_pkg::CFG_FADE_LENGTH)
            begin
                length_reg <= cfg_data[LW-1:0];
            end
            if (pix_accept && pix_in.last && frame_reg != '1)
            begin
                frame_reg <= frame_reg + FRAME_COUNT_BITS'(1);
            end
            if (cmd.setup)
            begin
                fading_reg <= fading_next;
                zero_reg   <= zero_next;
                cnt_reg    <= '0;
            end
            if (cmd.step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.commit)
            begin
                gain_reg      <= gain_new;
                g3_reg        <= g3_new;
                chroma_on_reg <= g3_new < (G3_W'(1) << (GAIN_FRAC_BITS + 1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            rem_reg  <= remain[LW-1:0];
            quot_reg <= '0;
        end
        if (cmd.step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[GAIN_FRAC_BITS-2:0], ge};
        end
    end

    // per-pixel scaling
    always_comb
    begin
        y_diff  = $signed({2'b00, pix_in.luma}) - 10'sd16;
        cb_diff = $signed({2'b00, pix_in.cb}) - 10'sd128;
        cr_diff = $signed({2'b00, pix_in.cr}) - 10'sd128;
        y_prod  = YP_W'(y_diff) * $signed({1'b0, gain_reg});
        cb_prod = CP_W'(cb_diff) * $signed({1'b0, g3_reg});
        cr_prod = CP_W'(cr_diff) * $signed({1'b0, g3_reg});
        y_shr   = y_prod >>> GAIN_FRAC_BITS;
        cb_shr  = cb_prod >>> (GAIN_FRAC_BITS + 1);
        cr_shr  = cr_prod >>> (GAIN_FRAC_BITS + 1);
        y_res   = $signed(y_shr[10:0]) + vftb_pkg::LUMA_BLACK;
        cb_res  = $signed(cb_shr[10:0]) + vftb_pkg::CHROMA_MID;
        cr_res  = $signed(cr_shr[10:0]) + vftb_pkg::CHROMA_MID;

        pix_out        = pix_in;
        if (fading_reg)
        begin
            pix_out.luma = clamp8(y_res);
            if (chroma_on_reg)
            begin
                pix_out.cb = clamp8(cb_res);
                pix_out.cr = clamp8(cr_res);
            end
        end
        if (!pix_in.chroma)
        begin
            pix_out.cb = '0;
            pix_out.cr = '0;
        end
    end

endmodule

// File: rtl/core/vftb_outbuf.sv
// ----------------------------------------------------------------------------
// vftb_outbuf
// Two-entry result buffer parting the input side from a stalled output.
// ----------------------------------------------------------------------------
module vftb_outbuf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  vftb_pkg::item_t  push_item,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output vftb_pkg::item_t  head
);

    vftb_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/core/video_fade_to_black_unit.sv
// ----------------------------------------------------------------------------
// video_fade_to_black_unit
// Fades a 4:2:0 pixel stream to black over a set number of frames.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    luma cb cr has_chroma last_of_frame
//  out       out_valid / out_stall  luma_out cb_out cr_out chroma_present frame_end
//  cfg       cfg_valid / cfg_ready  cfg_index cfg_data
//
//  One pixel per cycle while in_stall is low; its result is registered into a
//  two-entry output buffer. A last-of-frame pixel or a register write starts the
//  gain update: setup, serial divide, commit; in_stall and !cfg_ready hold throughout.
//  Output stalls back up into in_stall only once both buffer entries are full.
//  Reset leaves frame one, zero registers and zero gain; no clearing pass.
// ----------------------------------------------------------------------------
module video_fade_to_black_unit
#(
    parameter int GAIN_FRAC_BITS   = 16,
    parameter int FRAME_COUNT_BITS = 25
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       luma,
    input  logic [7:0]                       cb,
    input  logic [7:0]                       cr,
    input  logic                             has_chroma,
    input  logic                             last_of_frame,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       luma_out,
    output logic [7:0]                       cb_out,
    output logic [7:0]                       cr_out,
    output logic                             chroma_present,
    output logic                             frame_end,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vftb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vftb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    vftb_pkg::cmd_t    cmd;
    vftb_pkg::status_t status;
    vftb_pkg::item_t   pix_in;
    vftb_pkg::item_t   pix_res;
    vftb_pkg::item_t   head;
    logic              busy;
    logic              full;
    logic              pix_accept;
    logic              cfg_we;

    assign in_stall   = busy || full;
    assign cfg_ready  = !busy;
    assign pix_accept = in_valid && !in_stall;
    assign cfg_we     = cfg_valid && cfg_ready;

    assign pix_in.luma   = luma;
    assign pix_in.cb     = cb;
    assign pix_in.cr     = cr;
    assign pix_in.chroma = has_chroma;
    assign pix_in.last   = last_of_frame;

    vftb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_we || (pix_accept && last_of_frame)),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    vftb_datapath
    #(
        .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pix_accept (pix_accept),
        .pix_in     (pix_in),
        .cmd        (cmd),
        .status     (status),
        .pix_out    (pix_res)
    );

    vftb_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pix_accept),
        .push_item (pix_res),
        .pop       (out_valid && !out_stall),
        .full      (full),
        .not_empty (out_valid),
        .head      (head)
    );

    assign luma_out       = head.luma;
    assign cb_out         = head.cb;
    assign cr_out         = head.cr;
    assign chroma_present = head.chroma;
    assign frame_end      = head.last;

endmodule

// File: rtl/core/vftb_checker.sv
// ----------------------------------------------------------------------------
// vftb_checker
// Port-level checks on the fade-to-black unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "video_fade_to_black_unit_macros.svh"

module vftb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       last_of_frame,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] cb_out,
    input logic [7:0] cr_out,
    input logic       chroma_present,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    `VFTB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `VFTB_ASSERT_IMP(a_no_chroma_zero, clk, rst_n, out_valid && !chroma_present, cb_out == 8'd0 && cr_out == 8'd0)
    `VFTB_ASSERT_NXT(a_cfg_recompute, clk, rst_n, cfg_valid && cfg_ready, in_stall && !cfg_ready)
    `VFTB_ASSERT_NXT(a_frame_recompute, clk, rst_n, in_valid && !in_stall && last_of_frame, in_stall && !cfg_ready)

endmodule

bind video_fade_to_black_unit vftb_checker u_vftb_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .last_of_frame  (last_of_frame),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cb_out         (cb_out),
    .cr_out         (cr_out),
    .chroma_present (chroma_present),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready)
);
